### rtl/core/ilffa_pkg.sv
`timescale 1ns / 1ps

package ilffa_pkg;

	localparam int HEAP_BYTES_DEF  = 65536;
	localparam int CHUNK_BYTES_DEF = 4096;

	localparam int OP_W    = 2;
	localparam int ADDR_W  = 16;
	localparam int SIZE_W  = 17;

	localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
	localparam logic [OP_W-1:0] OP_MALLOC  = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE    = 2'd2;
	localparam logic [OP_W-1:0] OP_REALLOC = 2'd3;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_OOM  = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] block_addr;
		logic [SIZE_W-1:0] request_size;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_addr;
		logic              status;
		logic [ADDR_W-1:0] copy_src;
		logic [SIZE_W-1:0] copy_bytes;
	} out_item_t;

endpackage

### rtl/core/implicit_list_first_fit_allocator.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_ready      in_data   (op, block_addr, request_size)
// out       output     out_valid / out_ready    out_data  (result_addr, status, copy_src,
//                                                          copy_bytes)
// cfg       input      cfg_we                   cfg_wdata (heap_limit)
//
// One item at a time. Malloc walks the blocks first-fit and grows the heap when none fits;
// realloc adds a free on a move.
// The walk reads the headers through the single tag memory port.
// Reset clears break and control; the tag memory is not cleared.
// The result sits in an output register; the next item is taken once it is loaded.

module implicit_list_first_fit_allocator #(
	parameter int HEAP_BYTES  = ilffa_pkg::HEAP_BYTES_DEF,
	parameter int CHUNK_BYTES = ilffa_pkg::CHUNK_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ilffa_pkg::in_item_t           in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ilffa_pkg::out_item_t          out_data,
	input  logic                          cfg_we,
	input  logic [ilffa_pkg::SIZE_W-1:0]  cfg_wdata
);

	localparam int A_W   = $clog2(HEAP_BYTES);
	localparam int TAG_W = A_W + 1;
	localparam int IDX_W = A_W - 2;
	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int X     = ((TAG_W > 18) ? TAG_W : 18) + 1;
	localparam int CHUNK_R = ((CHUNK_BYTES + 7) / 8) * 8;
	localparam int SW    = ilffa_pkg::SIZE_W;
	localparam int AW    = ilffa_pkg::ADDR_W;

	typedef enum logic [24:0] {
		S_IDLE  = 25'h0000001,
		S_INIT  = 25'h0000002,
		S_GROW  = 25'h0000004,
		S_GROW2 = 25'h0000008,
		S_GROW3 = 25'h0000010,
		S_FIT1  = 25'h0000020,
		S_FIT2  = 25'h0000040,
		S_RA1   = 25'h0000080,
		S_RA2   = 25'h0000100,
		S_PLC1  = 25'h0000200,
		S_PLC2  = 25'h0000400,
		S_PLC3  = 25'h0000800,
		S_PLC4  = 25'h0001000,
		S_PLC5  = 25'h0002000,
		S_FREE1 = 25'h0004000,
		S_FREE2 = 25'h0008000,
		S_FREE3 = 25'h0010000,
		S_MRG1  = 25'h0020000,
		S_MRG2  = 25'h0040000,
		S_MRG3  = 25'h0080000,
		S_MRG4  = 25'h0100000,
		S_MRG5  = 25'h0200000,
		S_MRG6  = 25'h0400000,
		S_MRG7  = 25'h0800000,
		S_DONE  = 25'h1000000
	} state_t;

	state_t st_q;

	logic [TAG_W-1:0] tag_mem [DEPTH];
	logic [TAG_W-1:0] rd_q;
	logic [X-1:0]     mem_addr;
	logic             mem_we;
	logic [TAG_W-1:0] mem_wd;

	logic [SW-1:0] heap_limit_q;
	logic [X-1:0]  brk_q, ptr_q, need_q, bp_q, cur_q, sz_q, old_q, prev_q, nsz_q, ext_q, tot_q;
	logic          na_q, split_q, init_q, grow_q, mv_q, fail_q;
	logic [1:0]    k_q;
	logic [AW-1:0] res_q, src_q;
	logic [SW-1:0] cnt_q;

	logic [X-1:0] lim, rsz, in_a, in_req, in_need, ext_need, place_sz;
	logic         in_ok;
	logic         grow_ok;

	assign lim      = (X'(heap_limit_q) < X'(HEAP_BYTES)) ? X'(heap_limit_q) : X'(HEAP_BYTES);
	assign rsz      = X'({rd_q[TAG_W-1:3], 3'b000});
	assign in_a     = X'(in_data.block_addr);
	assign in_req   = X'(in_data.request_size);
	assign in_need  = (in_req + X'(15)) & ~X'(7);
	assign in_ok    = (in_a[2:0] == 3'b000) && (in_a >= X'(16)) && (in_a < brk_q);
	assign ext_need = (need_q > X'(CHUNK_R)) ? need_q : X'(CHUNK_R);
	assign place_sz = split_q ? need_q : tot_q;
	assign grow_ok  = !(brk_q > lim || ext_q > lim - brk_q);
	assign in_ready = (st_q == S_IDLE);

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = bp_q - X'(4);
		mem_wd   = '0;
		case (st_q)
			S_INIT: begin
				mem_we   = 1'b1;
				mem_addr = X'({k_q, 2'b00});
				case (k_q)
					2'd0:    mem_wd = '0;
					2'd3:    mem_wd = TAG_W'(1);
					default: mem_wd = TAG_W'(9);
				endcase
			end
			S_GROW: begin
				mem_we   = grow_ok;
				mem_addr = brk_q - X'(4);
				mem_wd   = TAG_W'(ext_q);
			end
			S_GROW2: begin
				mem_we   = 1'b1;
				mem_addr = bp_q + ext_q - X'(8);
				mem_wd   = TAG_W'(ext_q);
			end
			S_GROW3: begin
				mem_we   = 1'b1;
				mem_addr = bp_q + ext_q - X'(4);
				mem_wd   = TAG_W'(1);
			end
			S_FIT1:  mem_addr = cur_q - X'(4);
			S_RA1:   mem_addr = ptr_q - X'(4);
			S_PLC2: begin
				mem_we   = 1'b1;
				mem_wd   = TAG_W'(((rsz >= need_q) && (rsz - need_q >= X'(16)))
					? need_q : rsz) | TAG_W'(1);
			end
			S_PLC3: begin
				mem_we   = 1'b1;
				mem_addr = bp_q + place_sz - X'(8);
				mem_wd   = TAG_W'(place_sz) | TAG_W'(1);
			end
			S_PLC4: begin
				mem_we   = 1'b1;
				mem_addr = bp_q + need_q - X'(4);
				mem_wd   = TAG_W'(tot_q - need_q);
			end
			S_PLC5: begin
				mem_we   = 1'b1;
				mem_addr = bp_q + tot_q - X'(8);
				mem_wd   = TAG_W'(tot_q - need_q);
			end
			S_FREE2: begin
				mem_we   = 1'b1;
				mem_wd   = TAG_W'(rsz);
			end
			S_FREE3: begin
				mem_we   = 1'b1;
				mem_addr = bp_q + sz_q - X'(8);
				mem_wd   = TAG_W'(sz_q);
			end
			S_MRG2:  mem_addr = bp_q - X'(8);
			S_MRG3:  mem_addr = bp_q + sz_q - X'(4);
			S_MRG4:  mem_addr = prev_q - X'(4);
			S_MRG6: begin
				mem_we   = 1'b1;
				mem_wd   = TAG_W'(sz_q);
			end
			S_MRG7: begin
				mem_we   = 1'b1;
				mem_addr = bp_q + sz_q - X'(8);
				mem_wd   = TAG_W'(sz_q);
			end
			default: mem_addr = bp_q - X'(4);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[mem_addr[A_W-1:2]] <= mem_wd;
		end
		rd_q <= tag_mem[mem_addr[IDX_W+1:2]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= SW'(65536);
		end else if (cfg_we) begin
			heap_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			brk_q     <= '0;
			out_valid <= 1'b0;
			out_data  <= '0;
			ptr_q <= '0; need_q <= '0; bp_q <= '0; cur_q <= '0; sz_q <= '0;
			old_q <= '0; prev_q <= '0; nsz_q <= '0; ext_q <= '0; tot_q <= '0;
			na_q <= 1'b0; split_q <= 1'b0; init_q <= 1'b0; grow_q <= 1'b0;
			mv_q <= 1'b0; fail_q <= 1'b0; k_q <= '0;
			res_q <= '0; src_q <= '0; cnt_q <= '0;
		end else begin
			if (out_valid && out_ready && st_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						ptr_q  <= in_a;
						need_q <= in_need;
						bp_q   <= in_a;
						cur_q  <= X'(8);
						res_q  <= '0;
						src_q  <= '0;
						cnt_q  <= '0;
						fail_q <= 1'b0;
						init_q <= 1'b0;
						mv_q   <= 1'b0;
						grow_q <= 1'b0;
						k_q    <= '0;
						st_q   <= S_DONE;
						if (in_data.op == ilffa_pkg::OP_INIT) begin
							init_q <= 1'b1;
							ext_q  <= X'(CHUNK_R);
							if (lim < X'(16)) begin
								brk_q  <= '0;
								fail_q <= 1'b1;
							end else begin
								brk_q <= X'(16);
								st_q  <= S_INIT;
							end
						end else if (brk_q < X'(16)) begin
							fail_q <= (in_data.op != ilffa_pkg::OP_FREE);
						end else if (in_data.op == ilffa_pkg::OP_MALLOC ||
							(in_data.op == ilffa_pkg::OP_REALLOC && in_a == '0)) begin
							if (in_req != '0) begin
								st_q <= S_FIT1;
							end
						end else if (in_data.op == ilffa_pkg::OP_FREE) begin
							if (in_ok) begin
								st_q <= S_FREE1;
							end
						end else if (in_ok) begin
							st_q <= (in_req == '0) ? S_FREE1 : S_RA1;
						end
					end
				end
				S_INIT: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						st_q <= S_GROW;
					end
				end
				S_GROW: begin
					if (!grow_ok) begin
						fail_q <= 1'b1;
						res_q  <= '0;
						st_q   <= S_DONE;
					end else begin
						bp_q  <= brk_q;
						brk_q <= brk_q + ext_q;
						st_q  <= S_GROW2;
					end
				end
				S_GROW2: st_q <= S_GROW3;
				S_GROW3: begin
					grow_q <= 1'b1;
					st_q   <= S_MRG1;
				end
				S_FIT1: begin
					if (cur_q >= brk_q) begin
						ext_q <= ext_need;
						st_q  <= S_GROW;
					end else begin
						st_q <= S_FIT2;
					end
				end
				S_FIT2: begin
					if (rsz == '0) begin
						ext_q <= ext_need;
						st_q  <= S_GROW;
					end else if (!rd_q[0] && rsz >= need_q) begin
						res_q <= cur_q[AW-1:0];
						bp_q  <= cur_q;
						st_q  <= S_PLC1;
					end else begin
						cur_q <= cur_q + rsz;
						st_q  <= S_FIT1;
					end
				end
				S_RA1: st_q <= S_RA2;
				S_RA2: begin
					old_q <= rsz;
					if (rsz >= need_q) begin
						res_q <= ptr_q[AW-1:0];
						st_q  <= (rsz - need_q >= X'(16)) ? S_PLC1 : S_DONE;
					end else begin
						mv_q <= 1'b1;
						st_q <= S_FIT1;
					end
				end
				S_PLC1: st_q <= S_PLC2;
				S_PLC2: begin
					tot_q   <= rsz;
					split_q <= (rsz >= need_q) && (rsz - need_q >= X'(16));
					st_q    <= S_PLC3;
				end
				S_PLC3, S_PLC5: begin
					if (st_q == S_PLC3 && split_q) begin
						st_q <= S_PLC4;
					end else if (mv_q) begin
						mv_q  <= 1'b0;
						src_q <= ptr_q[AW-1:0];
						cnt_q <= SW'(old_q - X'(8));
						bp_q  <= ptr_q;
						st_q  <= S_FREE1;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_PLC4:  st_q <= S_PLC5;
				S_FREE1: st_q <= S_FREE2;
				S_FREE2: begin
					sz_q <= rsz;
					st_q <= S_FREE3;
				end
				S_FREE3: begin
					grow_q <= 1'b0;
					st_q   <= S_MRG1;
				end
				S_MRG1: st_q <= S_MRG2;
				S_MRG2: begin
					sz_q <= rsz;
					st_q <= S_MRG3;
				end
				S_MRG3: begin
					prev_q <= bp_q - rsz;
					st_q   <= S_MRG4;
				end
				S_MRG4: begin
					na_q  <= rd_q[0];
					nsz_q <= rsz;
					st_q  <= S_MRG5;
				end
				S_MRG5, S_MRG7: begin
					if (st_q == S_MRG5 && !(rd_q[0] && na_q)) begin
						sz_q <= sz_q + (na_q ? X'(0) : nsz_q) + (rd_q[0] ? X'(0) : rsz);
						if (!rd_q[0]) begin
							bp_q <= prev_q;
						end
						st_q <= S_MRG6;
					end else if (grow_q && !init_q) begin
						res_q <= bp_q[AW-1:0];
						st_q  <= S_PLC1;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_MRG6: st_q <= S_MRG7;
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid            <= 1'b1;
						out_data.result_addr <= res_q;
						out_data.status      <= fail_q ? ilffa_pkg::STATUS_OOM
							: ilffa_pkg::STATUS_DONE;
						out_data.copy_src    <= src_q;
						out_data.copy_bytes  <= cnt_q;
						st_q                 <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

### tb/tb_heap_checker.sv
`timescale 1ns / 1ps

module tb_heap_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  ilffa_pkg::in_item_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  ilffa_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [16:0]          cfg_wdata,
	input  logic                 closing,
	output int                   errors
);
	import ilffa_pkg::*;

	localparam int unsigned HEAP  = HEAP_BYTES_DEF;
	localparam int unsigned CHUNK = CHUNK_BYTES_DEF;
	localparam int unsigned DEPTH = HEAP / 4;

	int unsigned tag_mem [DEPTH];
	int unsigned brk_off;
	int unsigned lim_reg;
	bit          oom;
	out_item_t   due_answers[$];
	bit          closed;

	function automatic int unsigned tag_get(int unsigned a);
		return tag_mem[(a >> 2) % DEPTH];
	endfunction

	function automatic void tag_put(int unsigned a, int unsigned v);
		tag_mem[(a >> 2) % DEPTH] = v;
	endfunction

	function automatic int unsigned size_of(int unsigned bp);
		return tag_get(bp - 4) & ~32'd7;
	endfunction

	function automatic int unsigned used_of(int unsigned bp);
		return tag_get(bp - 4) & 32'd1;
	endfunction

	function automatic void mark(int unsigned bp, int unsigned sz, int unsigned al);
		tag_put(bp - 4, sz | al);
		tag_put(bp + sz - 8, sz | al);
	endfunction

	function automatic int unsigned eff_limit();
		return (lim_reg < HEAP) ? lim_reg : HEAP;
	endfunction

	function automatic int unsigned up8(int unsigned n);
		return (n + 7) & ~32'd7;
	endfunction

	function automatic int unsigned coalesce(int unsigned bp);
		int unsigned sz, prv, nxt, pa, na;
		sz  = size_of(bp);
		prv = bp - (tag_get(bp - 8) & ~32'd7);
		nxt = bp + sz;
		pa  = used_of(prv);
		na  = used_of(nxt);
		if (pa != 0 && na != 0)
			return bp;
		if (na == 0)
			sz += size_of(nxt);
		if (pa == 0) begin
			sz += size_of(prv);
			bp = prv;
		end
		mark(bp, sz, 0);
		return bp;
	endfunction

	function automatic int unsigned extend(int unsigned n);
		int unsigned a, lm, bp;
		a  = up8(n);
		lm = eff_limit();
		bp = brk_off;
		if (bp > lm || a > lm - bp)
			return 0;
		brk_off = bp + a;
		mark(bp, a, 0);
		tag_put(bp + a - 4, 1);
		return coalesce(bp);
	endfunction

	function automatic int unsigned scan_fit(int unsigned need);
		int unsigned cur, sz;
		cur = 8;
		for (int unsigned n = 0; n < DEPTH && cur < brk_off; n++) begin
			sz = size_of(cur);
			if (sz == 0)
				break;
			if (used_of(cur) == 0 && sz >= need)
				return cur;
			cur += sz;
		end
		return 0;
	endfunction

	function automatic void carve(int unsigned bp, int unsigned need);
		int unsigned tot;
		tot = size_of(bp);
		if (tot >= need && tot - need >= 16) begin
			mark(bp, need, 1);
			mark(bp + need, tot - need, 0);
		end else begin
			mark(bp, tot, 1);
		end
	endfunction

	function automatic int unsigned grab(int unsigned need);
		int unsigned bp;
		bp = scan_fit(need);
		if (bp == 0) begin
			bp = extend((need > CHUNK) ? need : CHUNK);
			if (bp == 0) begin
				oom = 1'b1;
				return 0;
			end
		end
		carve(bp, need);
		return bp;
	endfunction

	function automatic void release_blk(int unsigned bp);
		mark(bp, size_of(bp), 0);
		void'(coalesce(bp));
	endfunction

	function automatic bit ptr_ok(int unsigned a);
		return (a & 7) == 0 && a >= 16 && a < brk_off;
	endfunction

	function automatic out_item_t heap_answer(in_item_t it);
		out_item_t   r;
		int unsigned addr, req, res, src, cnt, need, old;
		addr = it.block_addr;
		req  = it.request_size;
		res  = 0;
		src  = 0;
		cnt  = 0;
		oom  = 1'b0;
		if (it.op == OP_INIT) begin
			brk_off = 0;
			if (eff_limit() < 16) begin
				oom = 1'b1;
			end else begin
				brk_off = 16;
				tag_put(0, 0);
				tag_put(4, 9);
				tag_put(8, 9);
				tag_put(12, 1);
				if (extend(CHUNK) == 0)
					oom = 1'b1;
			end
		end else if (brk_off < 16) begin
			if (it.op != OP_FREE)
				oom = 1'b1;
		end else if (it.op == OP_MALLOC || (it.op == OP_REALLOC && addr == 0)) begin
			if (req != 0)
				res = grab(up8(req + 8));
		end else if (it.op == OP_FREE) begin
			if (ptr_ok(addr))
				release_blk(addr);
		end else if (ptr_ok(addr)) begin
			if (req == 0) begin
				release_blk(addr);
			end else begin
				need = up8(req + 8);
				old  = size_of(addr);
				if (old >= need) begin
					if (old - need >= 16)
						carve(addr, need);
					res = addr;
				end else begin
					res = grab(need);
					if (!oom) begin
						src = addr;
						cnt = old - 8;
						release_blk(addr);
					end
				end
			end
		end
		r.result_addr = res[15:0];
		r.status      = oom ? STATUS_OOM : STATUS_DONE;
		r.copy_src    = src[15:0];
		r.copy_bytes  = cnt[16:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			brk_off = 0;
			lim_reg = 65536;
			errors  = 0;
			closed  = 1'b0;
			due_answers.delete();
		end else begin
			if (cfg_we)
				lim_reg = cfg_wdata;
			if (in_valid && in_ready)
				due_answers.push_back(heap_answer(in_data));
			if (out_valid && out_ready) begin
				if (due_answers.size() == 0) begin
					$error("unexpected item: addr %0d status %0d", out_data.result_addr,
						out_data.status);
					errors++;
				end else begin
					exp_r = due_answers.pop_front();
					if (exp_r.result_addr !== out_data.result_addr) begin
						$error("result_addr: expected %0d, got %0d", exp_r.result_addr,
							out_data.result_addr);
						errors++;
					end
					if (exp_r.status !== out_data.status) begin
						$error("status: expected %0d, got %0d", exp_r.status,
							out_data.status);
						errors++;
					end
					if (exp_r.copy_src !== out_data.copy_src) begin
						$error("copy_src: expected %0d, got %0d", exp_r.copy_src,
							out_data.copy_src);
						errors++;
					end
					if (exp_r.copy_bytes !== out_data.copy_bytes) begin
						$error("copy_bytes: expected %0d, got %0d", exp_r.copy_bytes,
							out_data.copy_bytes);
						errors++;
					end
				end
			end
			if (closing && !closed) begin
				closed = 1'b1;
				if (due_answers.size() != 0) begin
					$error("%0d items never arrived", due_answers.size());
					errors++;
				end
			end
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ilffa_pkg::*;

	localparam int STALL_LIMIT = 60000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [16:0] cfg_wdata = '0;
	logic        closing = 1'b0;
	int          errors;

	logic [1:0]  sent_op[$];
	int          sent_gen[$];
	int unsigned live_ptrs[$];
	int          gen = 0;
	bit          brisk = 1'b0;
	bit          hold_req = 1'b0;
	int          quiet = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	implicit_list_first_fit_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	tb_heap_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.closing  (closing),
		.errors   (errors)
	);

	// track returned pointers so frees of picked pointers only ever name live blocks
	always @(posedge clk) begin
		logic [1:0] op;
		int         g;
		if (out_valid && out_ready && sent_op.size() != 0) begin
			op = sent_op.pop_front();
			g  = sent_gen.pop_front();
			if ((op == OP_MALLOC || op == OP_REALLOC) && g == gen
					&& out_data.status == STATUS_DONE && out_data.result_addr != 0)
				live_ptrs.push_back(out_data.result_addr);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("FAIL implicit_list_first_fit_allocator");
			$finish;
		end
	end

	initial begin
		int k;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				k = brisk ? 0 : $urandom_range(0, 10);
				if (k > 0) begin
					out_ready <= 1'b0;
					repeat (k) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid) @(negedge clk);
			@(posedge clk);
		end
	end

	task automatic send(logic [1:0] op, int unsigned addr, int unsigned req);
		int k;
		k = brisk ? 0 : $urandom_range(0, 10);
		if (k > 0) begin
			in_valid <= 1'b0;
			repeat (k) @(posedge clk);
		end
		if (op == OP_INIT) begin
			gen++;
			live_ptrs.delete();
		end
		in_valid <= 1'b1;
		in_data  <= '{op: op, block_addr: addr[15:0], request_size: req[16:0]};
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		sent_op.push_back(op);
		sent_gen.push_back(gen);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sent_op.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_limit(int unsigned v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v[16:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int unsigned pick_ptr();
		int i;
		int unsigned p;
		i = $urandom_range(0, live_ptrs.size() - 1);
		p = live_ptrs[i];
		live_ptrs.delete(i);
		return p;
	endfunction

	function automatic int unsigned rand_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 120);
		if (r < 92)
			return $urandom_range(121, 3000);
		if (r < 98)
			return $urandom_range(3001, 9000);
		return $urandom_range(9001, 131071);
	endfunction

	function automatic int unsigned bad_ptr();
		case ($urandom_range(0, 2))
			0: return $urandom_range(0, 15);
			1: return $urandom_range(0, 65535) | 1;
			default: return ($urandom_range(0, 65535) & ~32'd7) | 4;
		endcase
	endfunction

	task automatic random_run(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			if (i % 60 == 0)
				brisk = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 2)
				send(OP_INIT, 0, 0);
			else if (r < 8)
				send(($urandom_range(0, 1) != 0) ? OP_FREE : OP_REALLOC, bad_ptr(),
					rand_size());
			else if (r < 10)
				send(OP_REALLOC, 0, rand_size());
			else if (r < 12)
				send(OP_MALLOC, $urandom_range(0, 65535), 0);
			else if (r < 35 && live_ptrs.size() != 0)
				send(OP_FREE, pick_ptr(), $urandom_range(0, 131071));
			else if (r < 52 && live_ptrs.size() != 0)
				send(OP_REALLOC, pick_ptr(),
					($urandom_range(0, 15) == 0) ? 0 : rand_size());
			else
				send(OP_MALLOC, $urandom_range(0, 65535), rand_size());
		end
		brisk = 1'b0;
	endtask

	initial begin
		int unsigned p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no heap yet
		send(OP_MALLOC, 0, 24);
		send(OP_FREE, 16, 0);
		send(OP_REALLOC, 0, 8);

		set_limit(65536);
		send(OP_INIT, 0, 0);
		send(OP_MALLOC, 0, 0);
		send(OP_MALLOC, 0, 1);
		send(OP_MALLOC, 65535, 131071);
		send(OP_MALLOC, 0, 65536);
		send(OP_MALLOC, 0, 4096);
		send(OP_MALLOC, 0, 5000);
		send(OP_FREE, 0, 0);
		send(OP_FREE, 8, 0);
		send(OP_FREE, 16'hFFFF, 0);
		send(OP_REALLOC, 16'hFFF9, 40);
		send(OP_REALLOC, 0, 24);
		send(OP_MALLOC, 0, 200);
		drain();
		p = pick_ptr();
		send(OP_REALLOC, p, 16);
		drain();
		p = pick_ptr();
		send(OP_REALLOC, p, 3000);
		drain();
		p = pick_ptr();
		send(OP_REALLOC, p, 0);
		send(OP_FREE, pick_ptr(), 0);
		random_run(140);

		// fill the block while the receiver holds off
		drain();
		hold_req = 1'b1;
		for (int i = 0; i < 6; i++)
			send(OP_MALLOC, 0, $urandom_range(1, 64));

		set_limit(16);
		send(OP_INIT, 0, 0);
		send(OP_MALLOC, 0, 8);
		send(OP_REALLOC, 0, 8);
		random_run(15);

		set_limit(131071);
		send(OP_INIT, 0, 0);
		random_run(130);

		set_limit(8200);
		send(OP_INIT, 0, 0);
		random_run(130);

		drain();
		closing <= 1'b1;
		repeat (3) @(posedge clk);
		if (errors == 0)
			$display("PASS implicit_list_first_fit_allocator");
		else
			$display("FAIL implicit_list_first_fit_allocator");
		$finish;
	end

endmodule

### implicit_list_first_fit_allocator.f
rtl/core/ilffa_pkg.sv
rtl/core/implicit_list_first_fit_allocator.sv
tb/tb_heap_checker.sv
tb/tb_top.sv
